// ----- rtl/mcbd_pkg.sv -----
// Package for the box-filter downsampler: sizes, register codes, FSM states
// and the line store write bundle. No dependencies.
`default_nettype none
package mcbd_pkg;

  localparam int MAX_DST_WIDTH  = 64;
  localparam int MAX_COMPONENTS = 4;
  localparam int MAX_FACTOR     = 64;
  localparam int MAX_SRC_DIM    = 4096;

  localparam int COL_W  = $clog2(MAX_DST_WIDTH);
  localparam int POS_W  = $clog2(MAX_SRC_DIM);
  localparam int REM_W  = $clog2(MAX_FACTOR);
  localparam int COMP_W = 8;
  localparam int SUM_W  = 20;
  localparam int CNT_W  = 13;
  localparam int DIV_STEPS_W = $clog2(SUM_W + 1);

  localparam int DIM_W = 13;
  localparam int DW_W  = 7;
  localparam int NC_W  = 3;
  localparam int F_W   = 7;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COMPONENTS = 3'd4;
  localparam logic [2:0] REG_FACTOR     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECALC,
    ST_ACC,
    ST_DIV,
    ST_EMIT_AVG,
    ST_ZERO
  } state_t;

  typedef struct packed {
    logic                                    en;
    logic [COL_W-1:0]                        addr;
    logic [MAX_COMPONENTS-1:0][SUM_W-1:0]    sums;
    logic [CNT_W-1:0]                        cnt;
  } store_wr_t;

endpackage
`default_nettype wire

// ----- rtl/mcbd_div_lane.sv -----
// One divider lane: restoring division, one quotient bit per cycle.
// Depends on mcbd_pkg.
`default_nettype none
module mcbd_div_lane (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [mcbd_pkg::SUM_W-1:0]    dividend,
  input  wire [mcbd_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [mcbd_pkg::SUM_W-1:0]   quotient,
  output logic [mcbd_pkg::CNT_W-1:0]   remainder
);
  import mcbd_pkg::*;

  logic                   busy;
  logic [DIV_STEPS_W-1:0] steps;
  logic [CNT_W-1:0]       dsor;
  logic [CNT_W:0]         trial;

  assign trial = {remainder, quotient[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        steps     <= DIV_STEPS_W'(SUM_W);
        quotient  <= dividend;
        remainder <= '0;
        dsor      <= divisor;
      end else if (busy) begin
        // shift in one dividend bit, subtract where it fits
        if (trial >= {1'b0, dsor}) begin
          remainder <= CNT_W'(trial - {1'b0, dsor});
          quotient  <= {quotient[SUM_W-2:0], 1'b1};
        end else begin
          remainder <= trial[CNT_W-1:0];
          quotient  <= {quotient[SUM_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == DIV_STEPS_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/mcbd_line_store.sv -----
// Line store: one sum bank per component lane plus the pixel count bank.
// Depends on mcbd_pkg.
`default_nettype none
module mcbd_line_store (
  input  wire                                                   clk,
  input  wire                                                   rd_en,
  input  wire [mcbd_pkg::COL_W-1:0]                             rd_addr,
  input  mcbd_pkg::store_wr_t                                   wr,
  output logic [mcbd_pkg::MAX_COMPONENTS-1:0][mcbd_pkg::SUM_W-1:0] rd_sums,
  output logic [mcbd_pkg::CNT_W-1:0]                            rd_cnt
);
  import mcbd_pkg::*;

  logic [SUM_W-1:0] sum_mem [MAX_COMPONENTS][MAX_DST_WIDTH];
  logic [CNT_W-1:0] cnt_mem [MAX_DST_WIDTH];

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_COMPONENTS; k++) begin
      if (wr.en) sum_mem[k][wr.addr] <= wr.sums[k];
      if (rd_en) rd_sums[k] <= sum_mem[k][rd_addr];
    end
    if (wr.en) cnt_mem[wr.addr] <= wr.cnt;
    if (rd_en) rd_cnt <= cnt_mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- rtl/mcbd_merge.sv -----
// Merge stage: turns lane quotients into saturated 8-bit averages,
// zeroing unused components and empty blocks. Depends on mcbd_pkg.
`default_nettype none
module mcbd_merge (
  input  wire [mcbd_pkg::MAX_COMPONENTS-1:0][mcbd_pkg::SUM_W-1:0]  quot,
  input  wire                                                     cnt_zero,
  input  wire [mcbd_pkg::NC_W-1:0]                                ncomp,
  output logic [mcbd_pkg::MAX_COMPONENTS-1:0][mcbd_pkg::COMP_W-1:0] avg
);
  import mcbd_pkg::*;

  always_comb begin
    for (int k = 0; k < MAX_COMPONENTS; k++) begin
      if (cnt_zero || NC_W'(k) >= ncomp) avg[k] = '0;
      else if (quot[k] > SUM_W'(255)) avg[k] = 8'hFF;
      else avg[k] = quot[k][COMP_W-1:0];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/multi_component_box_downsampler.sv -----
// Top level of the area-average downsampler: APB registers, position
// counters, sequencer and output register. Uses mcbd_pkg, mcbd_line_store,
// mcbd_div_lane and mcbd_merge.
//
//  channel  handshake               payload
//  in       in_valid / in_stall     req_type, in_c0..in_c3
//  out      out_valid / out_stall   out_c0..out_c3, dst_col, dst_row, last_in_run
//  cfg      APB psel/penable        paddr, pwdata, prdata (pready tied high)
//
// A source pixel is accepted, then its line store entry is read-modify-written.
// A pixel that closes a block then runs the four divider lanes in parallel
// and emits its result beat. Zero beats go one a cycle while out_stall is low.
// Any register write triggers a recompute of block position through
// the same lanes; a write during a recompute queues another; input stalls
// meanwhile. Reset is synchronous.
// Output beats hold while out_stall is high; the sequencer waits on them.
`default_nettype none
module multi_component_box_downsampler (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         req_type,
  input  wire  [7:0]  in_c0,
  input  wire  [7:0]  in_c1,
  input  wire  [7:0]  in_c2,
  input  wire  [7:0]  in_c3,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_c0,
  output logic [7:0]  out_c1,
  output logic [7:0]  out_c2,
  output logic [7:0]  out_c3,
  output logic [5:0]  dst_col,
  output logic [11:0] dst_row,
  output logic        last_in_run,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mcbd_pkg::*;

  // configuration registers, raw as written
  logic [DIM_W-1:0] src_width, src_height, dst_height;
  logic [DW_W-1:0]  dst_width;
  logic [NC_W-1:0]  components;
  logic [F_W-1:0]   block_factor;

  // clamped working values
  logic [DIM_W-1:0] w_eff, h_eff, dh_eff;
  logic [DW_W-1:0]  dw_eff;
  logic [NC_W-1:0]  c_eff;
  logic [F_W-1:0]   f_eff;

  // source position and its block coordinates
  logic [POS_W-1:0] x, y, bi, bj, ndr;
  logic [REM_W-1:0] xr, yr;
  logic [DIM_W-1:0] wblocks;
  logic             recalc_pend;

  state_t state, state_next;

  // per-item registers
  logic [MAX_COMPONENTS-1:0][COMP_W-1:0] px;
  logic             first_q, inside_q, emit_q, zrun_q;
  logic [POS_W-1:0] cur_i, zrow;
  logic [COL_W-1:0] cur_j;
  logic [DW_W-1:0]  zcol;
  logic [CNT_W-1:0] cnt_q;

  logic cfg_wr, in_acc, out_free, drain_ok, zrun_go, zlast, lane_done, div_start;
  logic band_end, col_end, line_end;
  logic [POS_W:0]   y_lim, x_lim;
  logic [POS_W+F_W-1:0] ndr_prod;

  logic [MAX_COMPONENTS-1:0][SUM_W-1:0] rd_sums, new_sums, div_num, quot;
  logic [MAX_COMPONENTS-1:0][CNT_W-1:0] rems;
  logic [MAX_COMPONENTS-1:0]            lane_dn;
  logic [MAX_COMPONENTS-1:0][COMP_W-1:0] avg;
  logic [CNT_W-1:0] rd_cnt, new_cnt, div_den;
  store_wr_t        st_wr;

  // clamp registers into range
  assign w_eff  = (src_width == '0) ? DIM_W'(1) :
                  (src_width > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : src_width;
  assign h_eff  = (src_height == '0) ? DIM_W'(1) :
                  (src_height > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : src_height;
  assign dh_eff = (dst_height == '0) ? DIM_W'(1) :
                  (dst_height > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : dst_height;
  assign dw_eff = (dst_width == '0) ? DW_W'(1) :
                  (dst_width > DW_W'(MAX_DST_WIDTH)) ? DW_W'(MAX_DST_WIDTH) : dst_width;
  assign c_eff  = (components == '0) ? NC_W'(1) :
                  (components > NC_W'(MAX_COMPONENTS)) ? NC_W'(MAX_COMPONENTS) : components;
  assign f_eff  = (block_factor == '0) ? F_W'(1) :
                  (block_factor > F_W'(MAX_FACTOR)) ? F_W'(MAX_FACTOR) : block_factor;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_SRC_WIDTH:  prdata = 32'(src_width);
      REG_SRC_HEIGHT: prdata = 32'(src_height);
      REG_DST_WIDTH:  prdata = 32'(dst_width);
      REG_DST_HEIGHT: prdata = 32'(dst_height);
      REG_COMPONENTS: prdata = 32'(components);
      REG_FACTOR:     prdata = 32'(block_factor);
      default:        prdata = '0;
    endcase
  end

  // block edges of the current pixel: first row/column past the block
  assign y_lim    = {1'b0, y} - (POS_W+1)'(yr) + (POS_W+1)'(f_eff);
  assign x_lim    = {1'b0, x} - (POS_W+1)'(xr) + (POS_W+1)'(f_eff);
  assign band_end = ({1'b0, y} + 1'b1 >= y_lim) || (DIM_W'(y) + 1'b1 >= h_eff);
  assign col_end  = ({1'b0, x} + 1'b1 >= x_lim) || (DIM_W'(x) + 1'b1 >= w_eff);
  assign line_end = DIM_W'(x) + 1'b1 >= w_eff;

  assign ndr_prod = (POS_W+F_W)'(ndr) * (POS_W+F_W)'(f_eff);
  assign drain_ok = (DIM_W'(ndr) < dh_eff) && (ndr_prod >= (POS_W+F_W)'(h_eff));

  assign out_free  = !out_valid || !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign zrun_go   = zrun_q && (wblocks < DIM_W'(dw_eff));
  assign zlast     = zcol + 1'b1 >= dw_eff;
  assign lane_done = lane_dn[0];

  // read-modify-write of the line store entry
  always_comb begin
    for (int k = 0; k < MAX_COMPONENTS; k++) begin
      if (NC_W'(k) < c_eff)
        new_sums[k] = first_q ? SUM_W'(px[k]) : rd_sums[k] + SUM_W'(px[k]);
      else
        new_sums[k] = rd_sums[k];
    end
    new_cnt = first_q ? CNT_W'(1) : rd_cnt + 1'b1;
  end

  always_comb begin
    st_wr.en   = (state == ST_ACC) && inside_q;
    st_wr.addr = cur_j;
    st_wr.sums = new_sums;
    st_wr.cnt  = new_cnt;
  end

  mcbd_line_store u_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (bj[COL_W-1:0]),
    .wr      (st_wr),
    .rd_sums (rd_sums),
    .rd_cnt  (rd_cnt)
  );

  // lanes either average a block or recompute block coordinates
  always_comb begin
    if (state == ST_ACC) begin
      div_num = new_sums;
      div_den = new_cnt;
    end else begin
      div_num    = '0;
      div_num[0] = SUM_W'(x);
      div_num[1] = SUM_W'(y);
      div_num[2] = SUM_W'(w_eff) + SUM_W'(f_eff) - 1'b1;
      div_den    = CNT_W'(f_eff);
    end
  end

  for (genvar g = 0; g < MAX_COMPONENTS; g++) begin : g_lane
    mcbd_div_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .start     (div_start),
      .dividend  (div_num[g]),
      .divisor   (div_den),
      .done      (lane_dn[g]),
      .quotient  (quot[g]),
      .remainder (rems[g])
    );
  end

  mcbd_merge u_merge (
    .quot     (quot),
    .cnt_zero (cnt_q == '0),
    .ncomp    (c_eff),
    .avg      (avg)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (recalc_pend) state_next = ST_RECALC;
        else if (in_acc && !req_type) state_next = ST_ACC;
        else if (in_acc && drain_ok) state_next = ST_ZERO;
      end
      ST_RECALC:   if (lane_done) state_next = ST_IDLE;
      ST_ACC: begin
        if (emit_q) state_next = ST_DIV;
        else if (zrun_go) state_next = ST_ZERO;
        else state_next = ST_IDLE;
      end
      ST_DIV:      if (lane_done) state_next = ST_EMIT_AVG;
      ST_EMIT_AVG: if (out_free) state_next = zrun_go ? ST_ZERO : ST_IDLE;
      ST_ZERO:     if (out_free && zlast) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = !((state == ST_IDLE) && !recalc_pend);
    div_start = ((state == ST_IDLE) && recalc_pend) || ((state == ST_ACC) && emit_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      src_width    <= DIM_W'(1);
      src_height   <= DIM_W'(1);
      dst_width    <= DW_W'(1);
      dst_height   <= DIM_W'(1);
      components   <= NC_W'(4);
      block_factor <= F_W'(1);
      x            <= '0;
      y            <= '0;
      bi           <= '0;
      bj           <= '0;
      xr           <= '0;
      yr           <= '0;
      wblocks      <= DIM_W'(1);
      ndr          <= '0;
      recalc_pend  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      // the recompute takes the register values as it starts
      if (state == ST_IDLE && recalc_pend) recalc_pend <= 1'b0;
      if (state == ST_RECALC && lane_done) begin
        bj      <= quot[0][POS_W-1:0];
        xr      <= rems[0][REM_W-1:0];
        bi      <= quot[1][POS_W-1:0];
        yr      <= rems[1][REM_W-1:0];
        wblocks <= quot[2][DIM_W-1:0];
      end
      if (cfg_wr) begin
        // any write may move the block grid: recompute before the next pixel
        recalc_pend <= 1'b1;
        case (paddr[4:2])
          REG_SRC_WIDTH:  src_width    <= pwdata[DIM_W-1:0];
          REG_SRC_HEIGHT: src_height   <= pwdata[DIM_W-1:0];
          REG_DST_WIDTH:  dst_width    <= pwdata[DW_W-1:0];
          REG_DST_HEIGHT: dst_height   <= pwdata[DIM_W-1:0];
          REG_COMPONENTS: components   <= pwdata[NC_W-1:0];
          REG_FACTOR:     block_factor <= pwdata[F_W-1:0];
          default: ;
        endcase
      end

      if (in_acc && !req_type) begin
        px       <= {in_c3, in_c2, in_c1, in_c0};
        first_q  <= (xr == '0) && (yr == '0);
        inside_q <= (DIM_W'(bi) < dh_eff) && (bj < POS_W'(dw_eff));
        emit_q   <= (DIM_W'(bi) < dh_eff) && (bj < POS_W'(dw_eff)) && band_end && col_end;
        zrun_q   <= (DIM_W'(bi) < dh_eff) && band_end && line_end;
        cur_i    <= bi;
        cur_j    <= bj[COL_W-1:0];
        if (x == '0 && y == '0) ndr <= '0;
        if ((DIM_W'(bi) < dh_eff) && band_end && line_end) ndr <= bi + 1'b1;
        // advance the raster position and its block coordinates
        if (line_end) begin
          x  <= '0;
          xr <= '0;
          bj <= '0;
          if (DIM_W'(y) + 1'b1 >= h_eff) begin
            y  <= '0;
            yr <= '0;
            bi <= '0;
          end else begin
            y <= y + 1'b1;
            if (F_W'(yr) + 1'b1 == f_eff) begin
              yr <= '0;
              bi <= bi + 1'b1;
            end else begin
              yr <= yr + 1'b1;
            end
          end
        end else begin
          x <= x + 1'b1;
          if (F_W'(xr) + 1'b1 == f_eff) begin
            xr <= '0;
            bj <= bj + 1'b1;
          end else begin
            xr <= xr + 1'b1;
          end
        end
      end

      if (in_acc && req_type && drain_ok) begin
        zcol <= '0;
        zrow <= ndr;
        ndr  <= ndr + 1'b1;
      end

      if (state == ST_ACC) begin
        zcol  <= wblocks[DW_W-1:0];
        zrow  <= cur_i;
        cnt_q <= new_cnt;
      end

      // drop a taken beat, then load a new one where due
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == ST_EMIT_AVG && out_free) begin
        out_valid   <= 1'b1;
        out_c0      <= avg[0];
        out_c1      <= avg[1];
        out_c2      <= avg[2];
        out_c3      <= avg[3];
        dst_col     <= cur_j;
        dst_row     <= cur_i;
        last_in_run <= !zrun_go;
      end
      if (state == ST_ZERO && out_free) begin
        out_valid   <= 1'b1;
        out_c0      <= '0;
        out_c1      <= '0;
        out_c2      <= '0;
        out_c3      <= '0;
        dst_col     <= zcol[COL_W-1:0];
        dst_row     <= zrow;
        last_in_run <= zlast;
        zcol        <= zcol + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/mcbd_checker.sv -----
// Port-level checks for the downsampler, bound to the top level.
// Depends on multi_component_box_downsampler ports only.
`default_nettype none
module mcbd_port_props (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        req_type,
  input wire        out_valid,
  input wire        out_stall,
  input wire [7:0]  out_c0,
  input wire [5:0]  dst_col,
  input wire [11:0] dst_row,
  input wire        last_in_run,
  input wire        psel,
  input wire        penable,
  input wire        pwrite
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_c0) && $stable(dst_col)
      && $stable(dst_row) && $stable(last_in_run))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !req_type |=> in_stall)
    else $error("pixel not held for its store update");

  a_cfg_recalc: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> in_stall)
    else $error("input open before block grid recompute");
endmodule

bind multi_component_box_downsampler mcbd_port_props u_mcbd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .req_type    (req_type),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_c0      (out_c0),
  .dst_col     (dst_col),
  .dst_row     (dst_row),
  .last_in_run (last_in_run),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite)
);
`default_nettype wire

// ----- bench/mcbd_checker.sv -----
// Scoreboard for the box-filter downsampler: tracks register writes, predicts
// the averaged and zero beats for every accepted input beat and compares result beats.
// Depends on mcbd_pkg for register codes and sizes.
module mcbd_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire         req_type,
  input  wire  [7:0]  in_c0,
  input  wire  [7:0]  in_c1,
  input  wire  [7:0]  in_c2,
  input  wire  [7:0]  in_c3,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [7:0]  out_c0,
  input  wire  [7:0]  out_c1,
  input  wire  [7:0]  out_c2,
  input  wire  [7:0]  out_c3,
  input  wire  [5:0]  dst_col,
  input  wire  [11:0] dst_row,
  input  wire         last_in_run,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire         pready,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output int          fails,
  output int          pending,
  output int          checked
);
  import mcbd_pkg::*;

  typedef struct {
    logic [7:0]  c [4];
    logic [5:0]  col;
    logic [11:0] row;
    logic        last;
  } avg_beat_t;

  avg_beat_t avg_q[$];

  logic [12:0] src_w, src_h, dst_h;
  logic [6:0]  dst_w, fac;
  logic [2:0]  ncomp;
  int col_pos, row_pos, next_row;
  int col_sum [MAX_DST_WIDTH][4];
  int col_cnt [MAX_DST_WIDTH];

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic queue_beat(int a0, int a1, int a2, int a3, int col, int row);
    avg_beat_t b;
    b.c[0] = a0[7:0]; b.c[1] = a1[7:0]; b.c[2] = a2[7:0]; b.c[3] = a3[7:0];
    b.col = col[5:0];
    b.row = row[11:0];
    b.last = 1'b0;
    avg_q.push_back(b);
  endtask

  // Work out every beat caused by one input beat and advance the raster state.
  task automatic predict_averages(bit drain, int p0, int p1, int p2, int p3);
    int w, h, dw, dh, nc, f, x, y, i, j, cnt, start;
    int px [4];
    int avg [4];
    bit band_end, line_end, first;
    w = clip(src_w, 1, MAX_SRC_DIM);
    h = clip(src_h, 1, MAX_SRC_DIM);
    dw = clip(dst_w, 1, MAX_DST_WIDTH);
    dh = clip(dst_h, 1, MAX_SRC_DIM);
    nc = clip(ncomp, 1, MAX_COMPONENTS);
    f = clip(fac, 1, MAX_FACTOR);
    start = avg_q.size();
    px[0] = p0; px[1] = p1; px[2] = p2; px[3] = p3;
    if (drain) begin
      if (next_row < dh && next_row * f >= h) begin
        for (int k = 0; k < dw; k++) queue_beat(0, 0, 0, 0, k, next_row);
        next_row++;
      end
    end else begin
      x = col_pos; y = row_pos;
      i = y / f; j = x / f;
      band_end = (y + 1 >= clip(i * f + f, 0, h));
      line_end = (x + 1 >= w);
      if (x == 0 && y == 0) next_row = 0;
      if (i < dh && j < dw) begin
        first = (x % f == 0) && (y % f == 0);
        for (int k = 0; k < nc; k++)
          col_sum[j][k] = first ? px[k] : ((col_sum[j][k] + px[k]) & 20'hFFFFF);
        col_cnt[j] = first ? 1 : ((col_cnt[j] + 1) & 13'h1FFF);
        if (band_end && x + 1 >= clip(j * f + f, 0, w)) begin
          cnt = col_cnt[j];
          for (int k = 0; k < 4; k++) begin
            avg[k] = 0;
            if (cnt != 0 && k < nc) avg[k] = clip(col_sum[j][k] / cnt, 0, 255);
          end
          queue_beat(avg[0], avg[1], avg[2], avg[3], j, i);
        end
      end
      if (i < dh && band_end && line_end) begin
        // pad the band row out to the destination width
        for (int k = (w + f - 1) / f; k < dw; k++) queue_beat(0, 0, 0, 0, k, i);
        next_row = i + 1;
      end
      if (line_end) begin
        col_pos = 0;
        row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col_pos = x + 1;
      end
    end
    if (avg_q.size() > start) avg_q[avg_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      src_w <= 13'd1; src_h <= 13'd1; dst_w <= 7'd1; dst_h <= 13'd1;
      ncomp <= 3'd4; fac <= 7'd1;
      col_pos = 0; row_pos = 0; next_row = 0;
      avg_q.delete();
      fails <= 0;
      checked <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (avg_q.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("unexpected result beat col %0d row %0d", dst_col, dst_row);
        end else begin
          avg_beat_t e;
          e = avg_q.pop_front();
          if (e.c[0] !== out_c0 || e.c[1] !== out_c1 || e.c[2] !== out_c2 ||
              e.c[3] !== out_c3 || e.col !== dst_col || e.row !== dst_row ||
              e.last !== last_in_run) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("mismatch: expected %0d %0d %0d %0d col %0d row %0d last %0d, got %0d %0d %0d %0d col %0d row %0d last %0d",
                       e.c[0], e.c[1], e.c[2], e.c[3], e.col, e.row, e.last,
                       out_c0, out_c1, out_c2, out_c3, dst_col, dst_row, last_in_run);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_averages(req_type, in_c0, in_c1, in_c2, in_c3);
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SRC_WIDTH:  src_w <= pwdata[12:0];
          REG_SRC_HEIGHT: src_h <= pwdata[12:0];
          REG_DST_WIDTH:  dst_w <= pwdata[6:0];
          REG_DST_HEIGHT: dst_h <= pwdata[12:0];
          REG_COMPONENTS: ncomp <= pwdata[2:0];
          REG_FACTOR:     fac <= pwdata[6:0];
          default: ;
        endcase
      end
    end
    pending = avg_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the downsampler bench: clock, reset, register programming, pixel and
// drain stimulus, receiver stalls and the verdict. Uses mcbd_pkg, mcbd_checker
// and multi_component_box_downsampler.
module testbench;
  import mcbd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        req_type = 1'b0;
  logic [7:0]  in_c0 = '0, in_c1 = '0, in_c2 = '0, in_c3 = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_stall, out_valid, last_in_run, pready;
  logic [7:0]  out_c0, out_c1, out_c2, out_c3;
  logic [5:0]  dst_col;
  logic [11:0] dst_row;
  logic [31:0] prdata;

  int fails, pending, checked;
  int idle_pct = 0;      // chance in a hundred that the sender skips a cycle
  int stall_pct = 0;     // chance in a hundred that the receiver stalls
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  int quiet = 0;
  int beats_sent = 0, settings = 0;

  always #5 clk = ~clk;

  multi_component_box_downsampler uut (.*);

  mcbd_checker scoreboard (
    .clk, .rst, .in_valid, .in_stall, .req_type, .in_c0, .in_c1, .in_c2, .in_c3,
    .out_valid, .out_stall, .out_c0, .out_c1, .out_c2, .out_c3, .dst_col, .dst_row,
    .last_in_run, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fails, .pending, .checked
  );

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable) || rst) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet > 5000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offer one beat; entered and left at a falling edge with nothing yet driven.
  task automatic offer(bit drain, logic [7:0] a0, a1, a2, a3);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= drain;
    in_c0 <= a0; in_c1 <= a1; in_c2 <= a2; in_c3 <= a3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic offer_pixel();
    offer(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait until every predicted beat is out, then let the
  // divider lanes finish any work that produced nothing.
  task automatic drain_out();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (48) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_image(int w, int h, int dw, int dh, int nc, int f);
    drain_out();
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_COMPONENTS, nc);
    write_reg(REG_FACTOR, f);
    settings++;
  endtask

  task automatic set_pace(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 72; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 72; end
      default: begin idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  initial begin
    int w, h, f, dw, dh, used, phase;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: a one-pixel image, full and empty components, idle drain.
    offer(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    offer(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(1'b1, 8'hA5, 8'h5A, 8'hFF, 8'h00);

    // 5x3 into 4x3 with factor 2: an empty column, an empty row, and a zero
    // component count that clamps to one.
    set_image(5, 3, 4, 3, 0, 2);
    for (int k = 0; k < 15; k++) begin
      if (k % 2 == 0) offer(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      else offer(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    end
    offer(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    offer(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);

    // Shrink the width mid-row so the column count lands past the new width.
    set_image(8, 2, 2, 1, 4, 2);
    for (int k = 0; k < 5; k++) offer_pixel();
    drain_out();
    write_reg(REG_SRC_WIDTH, 4);
    for (int k = 0; k < 5; k++) offer_pixel();

    // Widest destination with the largest factor: one block spans the row, then the
    // other 63 columns of that row and a drained row of 64 come out as zero beats.
    set_image(64, 1, 64, 2, 4, 64);
    for (int k = 0; k < 64; k++) offer_pixel();
    offer(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);

    // Random whole images under rotating pace, with drains sprinkled in.
    phase = 0;
    used = beats_sent;
    while (phase < 4 || beats_sent - used < 60) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      f = $urandom_range(1, 4);
      dw = (w + f - 1) / f + $urandom_range(0, 2);
      if (dw > w) dw = w;
      dh = (h + f - 1) / f + $urandom_range(0, 2);
      if (dh > h) dh = h;
      set_image(w, h, dw, dh, $urandom_range(1, 4), f);
      set_pace(phase % 4);
      if (phase == 1) hold_req++;
      for (int k = 0; k < w * h; k++) begin
        if (phase == 2 && k == (w * h) / 2) drain_out();
        if ($urandom_range(9) == 0)
          offer(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        offer_pixel();
      end
      repeat (dh + 1) offer(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      set_pace(0);
      phase++;
    end

    drain_out();
    $display("sent %0d input beats under %0d register settings", beats_sent, settings);
    $display("checked %0d result beats against the prediction", checked);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
